@@ hw/rtl/spl_pkg.sv @@
// spl_pkg: shared widths, constants and controller/datapath interface structs
// for the smoothed peak locator. No dependencies.
package spl_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int P_W         = CNT_W;
	localparam int MAG_W       = 16;
	localparam int HW_W        = 7;
	localparam int WCNT_W      = HW_W + 1;
	localparam int SUM_W       = 24;
	localparam int DIVC_W      = $clog2(SUM_W + 1);

	localparam logic [HW_W-1:0]   MAX_HW       = HW_W'(64);
	localparam logic [HW_W-1:0]   HW_RESET     = HW_W'(8);
	localparam logic [CNT_W-1:0]  SAMPLE_LIMIT = CNT_W'(MAX_SAMPLES);
	localparam logic [DIVC_W-1:0] DIV_STEPS    = DIVC_W'(SUM_W);

	// controller -> datapath commands
	typedef struct packed {
		logic load;
		logic init;
		logic acc;
		logic mul;
		logic div_start;
		logic div_step;
		logic rec;
		logic advance;
		logic finish;
	} spl_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic update;
		logic is_last;
		logic div_done;
		logic out_busy;
	} spl_sts_t;

endpackage

@@ hw/rtl/smoothed_peak_locator_core.sv @@
// smoothed_peak_locator_core: top level, joins controller and datapath.
// Depends on spl_pkg, spl_ctrl, spl_dp (and spl_ram through spl_dp).
//
// Samples of a frame arrive one per cycle on the input channel; each is
// rectified and written into a 4096-entry magnitude store (two RAM copies,
// so both window edges can be read at once). Samples beyond 4096 in a
// frame are dropped. The sample flagged last_sample starts the search and
// the input channel stalls until it ends. The search walks the frame with a
// sliding window of half width W (half_window, 0 read as 1, above 64 read as
// 64): each step adds the leading magnitude, drops the trailing one, and
// tests avg > best as sum >= (best+1)*count, so the 24-step radix-2 divider
// only runs when the best average actually improves. A frame of n samples
// is searched over n+W-1 window positions; each position passes through
// the window step (RAM read, accumulate, multiply, compare), and each
// improvement of the best average adds a run of the divider. The
// result (first strictly largest average, peak_found=0 and index 0 if all
// averages are zero) sits in an output register until taken, and loading of
// the next frame proceeds meanwhile. half_window is written through the
// configuration channel, which is always ready, and is meant to change only
// while the block is idle.
module smoothed_peak_locator_core
	import spl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [MAG_W-1:0]  sample,
	input  logic                     last_sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ADDR_W-1:0]        peak_index,
	output logic                     peak_found,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [HW_W-1:0]          half_window
);

	spl_cmd_t cmd;
	spl_sts_t sts;

	// register writes complete in the cycle they are offered
	assign cfg_ready = 1'b1;

	spl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sample (last_sample),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	spl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (sample),
		.cfg_valid   (cfg_valid),
		.half_window (half_window),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.peak_index  (peak_index),
		.peak_found  (peak_found)
	);

`ifndef SYNTHESIS
	a_one_frame_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_sample) |=> !in_ready)
		else $error("input taken during search");
	a_found_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !peak_found) |-> (peak_index == '0))
		else $error("nonzero index without a peak");
	a_cfg_always: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel stalled");
`endif

endmodule

@@ hw/rtl/spl_ram.sv @@
// spl_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module spl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/spl_ctrl.sv @@
// spl_ctrl: sequencing state machine of the smoothed peak locator.
// Depends on spl_pkg (command/status structs).
module spl_ctrl
	import spl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      last_sample,
	output logic      in_ready,
	output spl_cmd_t  cmd,
	input  spl_sts_t  sts
);

	typedef enum logic [8:0] {
		S_LOAD = 9'b000000001,
		S_INIT = 9'b000000010,
		S_RD   = 9'b000000100,
		S_ACC  = 9'b000001000,
		S_MUL  = 9'b000010000,
		S_CMP  = 9'b000100000,
		S_DIV  = 9'b001000000,
		S_REC  = 9'b010000000,
		S_DONE = 9'b100000000
	} spl_state_t;

	spl_state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_sample) begin
						state_d = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_RD;
			end
			S_RD: begin
				// RAM read of both window edges in flight
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.update) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else if (sts.is_last) begin
					state_d = S_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_RD;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_REC;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_REC: begin
				cmd.rec = 1'b1;
				if (sts.is_last) begin
					state_d = S_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_RD;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> !in_ready)
		else $error("input accepted outside load phase");
	a_init_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_sample) |=> cmd.init)
		else $error("search did not start after last sample");
	a_one_exit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.div_start, cmd.advance, cmd.finish}))
		else $error("conflicting sequencer commands");
`endif

endmodule

@@ hw/rtl/spl_dp.sv @@
// spl_dp: datapath of the smoothed peak locator: sample store, sliding window
// sum, threshold multiply, radix-2 divider, best tracking and result register.
// Depends on spl_pkg and spl_ram.
module spl_dp
	import spl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  spl_cmd_t                 cmd,
	output spl_sts_t                 sts,
	input  logic signed [MAG_W-1:0]  sample,
	input  logic                     cfg_valid,
	input  logic [HW_W-1:0]          half_window,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ADDR_W-1:0]        peak_index,
	output logic                     peak_found
);

	// control registers
	logic [CNT_W-1:0]  count_q;
	logic [HW_W-1:0]   hw_q;
	logic              out_valid_q;
	// datapath registers
	logic [CNT_W-1:0]       n_q;
	logic [P_W-1:0]         p_q;
	logic [SUM_W-1:0]       sum_q;
	logic [WCNT_W-1:0]      wcnt_q;
	logic [MAG_W-1:0]       best_q;
	logic [ADDR_W-1:0]      pos_q;
	logic [MAG_W+WCNT_W:0]  prod_q;
	logic [SUM_W-1:0]       div_q;
	logic [WCNT_W-1:0]      rem_q;
	logic [DIVC_W-1:0]      div_cnt_q;
	logic [ADDR_W-1:0]      peak_index_q;
	logic                   peak_found_q;

	logic [MAG_W-1:0]   mag;
	logic               wr_en;
	logic [MAG_W-1:0]   rd_add, rd_sub;
	logic [HW_W-1:0]    weff, weff_m1;
	logic [WCNT_W-1:0]  w2;
	logic [P_W-1:0]     sub_idx, end_p, pos_now;
	logic               add_en, sub_en, eval;
	logic [MAG_W-1:0]   add_val, sub_val;
	logic [MAG_W:0]     best_inc;
	logic [WCNT_W:0]    trial;
	logic               fits;

	// rectify: most negative value maps to 0x8000
	assign mag   = sample[MAG_W-1] ? (~sample + 1'b1) : sample;
	assign wr_en = cmd.load && (count_q < SAMPLE_LIMIT);

	always_comb begin
		if (hw_q == '0) begin
			weff = HW_W'(1);
		end else if (hw_q > MAX_HW) begin
			weff = MAX_HW;
		end else begin
			weff = hw_q;
		end
	end

	assign weff_m1 = weff - HW_W'(1);
	assign w2      = {weff, 1'b0};

	// p_q is the leading (add) index; trailing index is p - 2W,
	// window center position is p - (W - 1)
	assign sub_idx = p_q - P_W'(w2);
	assign pos_now = p_q - P_W'(weff_m1);
	assign end_p   = n_q - CNT_W'(1) + P_W'(weff_m1);
	assign add_en  = p_q < n_q;
	assign sub_en  = p_q >= P_W'(w2);
	assign eval    = p_q >= P_W'(weff_m1);
	assign add_val = add_en ? rd_add : '0;
	assign sub_val = sub_en ? rd_sub : '0;
	assign best_inc = {1'b0, best_q} + (MAG_W+1)'(1);

	// restoring divider step
	assign trial = {rem_q, div_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, wcnt_q};

	spl_ram #(.WIDTH(MAG_W), .DEPTH(MAX_SAMPLES)) u_ram_add (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (mag),
		.raddr (p_q[ADDR_W-1:0]),
		.rdata (rd_add)
	);

	spl_ram #(.WIDTH(MAG_W), .DEPTH(MAX_SAMPLES)) u_ram_sub (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (mag),
		.raddr (sub_idx[ADDR_W-1:0]),
		.rdata (rd_sub)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			hw_q        <= HW_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				hw_q <= half_window;
			end
			if (cmd.init) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			n_q    <= count_q;
			p_q    <= '0;
			sum_q  <= '0;
			wcnt_q <= '0;
			best_q <= '0;
			pos_q  <= '0;
		end
		if (cmd.acc) begin
			sum_q  <= sum_q + SUM_W'(add_val) - SUM_W'(sub_val);
			wcnt_q <= wcnt_q + WCNT_W'(add_en) - WCNT_W'(sub_en);
		end
		if (cmd.mul) begin
			prod_q <= (MAG_W+WCNT_W+1)'(best_inc) * (MAG_W+WCNT_W+1)'(wcnt_q);
		end
		if (cmd.div_start) begin
			div_q     <= sum_q;
			rem_q     <= '0;
			div_cnt_q <= DIV_STEPS;
		end else if (cmd.div_step) begin
			div_q     <= {div_q[SUM_W-2:0], fits};
			rem_q     <= fits ? WCNT_W'(trial - {1'b0, wcnt_q}) : WCNT_W'(trial);
			div_cnt_q <= div_cnt_q - DIVC_W'(1);
		end
		if (cmd.rec) begin
			best_q <= div_q[MAG_W-1:0];
			pos_q  <= pos_now[ADDR_W-1:0];
		end
		if (cmd.advance) begin
			p_q <= p_q + P_W'(1);
		end
		if (cmd.finish) begin
			peak_found_q <= best_q != '0;
			peak_index_q <= (best_q != '0) ? pos_q : '0;
		end
	end

	// avg > best  <=>  sum >= (best + 1) * count
	assign sts.update   = eval && ({1'b0, sum_q} >= prod_q);
	assign sts.is_last  = p_q == end_p;
	assign sts.div_done = div_cnt_q == '0;
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign peak_index = peak_index_q;
	assign peak_found = peak_found_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SAMPLE_LIMIT)
		else $error("sample count past store depth");
	a_window_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul && eval) |-> (wcnt_q != '0))
		else $error("empty window at evaluated position");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < wcnt_q))
		else $error("divider remainder out of range");
	a_best_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rec |=> (best_q > $past(best_q)))
		else $error("recorded average not larger than previous best");
`endif

endmodule
